// ===== hdl/positional_list_engine_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared property wrappers, clocked on clock and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// Positional list engine package
// Sizes, command and status codes, sequencer states and the store port type.
// ---------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_BADPOS   = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_STEP,
      S_INS_WR,
      S_DEL_STEP,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_req_type;

endpackage

// ===== hdl/ple_store.sv =====
// ---------------------------------------------------------------------------
// Positional list entry store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ple_store import ple_pkg::*; (
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] entry_mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
// ---------------------------------------------------------------------------
// Positional list engine
// Rejected commands and an insert into an empty list go from idle straight to
// the response state. Other commands walk the list with the shared index
// stepper, reading an entry in one state and writing or comparing it in the
// next; a dump hands out one result item per entry. One item at a time; the
// entry store has one write port and one read port.
// Synchronous reset empties the list and drops any pending result item.
// ---------------------------------------------------------------------------
`include "positional_list_engine_unit_defines.svh"

module positional_list_engine_unit import ple_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [CNT_W-1:0]        req_position,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [CNT_W-1:0]        rsp_found_position,
   output logic signed [DATA_W-1:0] rsp_entry_value,
   output logic [CNT_W-1:0]        rsp_length,
   output logic                    rsp_last
);

   // sequencer and command registers
   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [DATA_W-1:0]  value_ff;
   logic [CNT_W-1:0]   pos_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   status_type         status_ff, status_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0]  rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]   rsp_length_ff, rsp_length_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_load;

   // store port
   mem_req_type        mem_req;
   logic [DATA_W-1:0]  rd_data;

   // decode and shared unit
   logic               req_accept;
   logic               out_free;
   cmd_type            in_cmd;
   logic               is_empty;
   logic               is_full;
   status_type         acc_status;
   logic               acc_walk;
   logic               step_dec;
   logic [CNT_W-1:0]   step_sum;
   logic               at_end;
   logic               at_pos;
   logic               hit;

   ple_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // Handshakes: take a command only when the sequencer is idle; the result
   // register frees up when empty or when its item is taken this cycle.
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Command check at acceptance. Full is tested before empty for insert;
   // an insert into an empty list lands at slot 0 right away.
   // ---------------------------------------------------------------------
   assign in_cmd   = cmd_type'(req_cmd);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      acc_status = STAT_OK;
      case (in_cmd)
         CMD_INSERT: begin
            if (is_full) begin
               acc_status = STAT_FULL;
            end else if (!is_empty && (req_position > count_ff)) begin
               acc_status = STAT_BADPOS;
            end
         end
         CMD_DELETE: begin
            if (is_empty) begin
               acc_status = STAT_EMPTY;
            end else if (req_position >= count_ff) begin
               acc_status = STAT_BADPOS;
            end
         end
         default: begin
            if (is_empty) begin
               acc_status = STAT_EMPTY;
            end
         end
      endcase
   end

   assign acc_walk = (acc_status == STAT_OK) && !((in_cmd == CMD_INSERT) && is_empty);

   // ---------------------------------------------------------------------
   // Shared index stepper: walks down while shifting up for insert, up for
   // everything else. The same sum feeds the shift read address and the end test.
   // ---------------------------------------------------------------------
   assign step_dec = (state_ff == S_INS_STEP) || (state_ff == S_INS_WR);
   assign step_sum = idx_ff + (step_dec ? {CNT_W{1'b1}} : CNT_W'(1));
   assign at_end   = (step_sum == count_ff);
   assign at_pos   = (idx_ff == pos_ff);
   assign hit      = (rd_data == value_ff);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (!acc_walk) begin
                  state_in = S_RESP;
               end else begin
                  case (in_cmd)
                     CMD_INSERT: state_in = S_INS_STEP;
                     CMD_DELETE: state_in = S_DEL_STEP;
                     CMD_SEARCH: state_in = S_SRCH_RD;
                     default:    state_in = S_DUMP_RD;
                  endcase
               end
            end
         end
         S_INS_STEP: state_in = at_pos ? S_RESP : S_INS_WR;
         S_INS_WR:   state_in = S_INS_STEP;
         S_DEL_STEP: state_in = at_end ? S_RESP : S_DEL_WR;
         S_DEL_WR:   state_in = S_DEL_STEP;
         S_SRCH_RD:  state_in = S_SRCH_CMP;
         S_SRCH_CMP: state_in = (hit || at_end) ? S_RESP : S_SRCH_RD;
         S_DUMP_RD:  state_in = S_DUMP_OUT;
         S_DUMP_OUT: begin
            if (out_free) begin
               state_in = at_end ? S_IDLE : S_DUMP_RD;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs: store accesses, index and count updates, result load
   // ---------------------------------------------------------------------
   always_comb begin
      mem_req       = '0;
      idx_in        = idx_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_load      = 1'b0;
      rsp_status_in = status_ff;
      rsp_found_in  = '0;
      rsp_entry_in  = '0;
      rsp_length_in = count_ff;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               status_in = acc_status;
               case (in_cmd)
                  CMD_INSERT: idx_in = count_ff;
                  CMD_DELETE: idx_in = req_position;
                  default:    idx_in = '0;
               endcase
               // first entry of an empty list: write it now
               if ((in_cmd == CMD_INSERT) && is_empty) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = '0;
                  mem_req.wr_data = req_value;
                  count_in        = CNT_W'(1);
               end
            end
         end
         S_INS_STEP: begin
            if (at_pos) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = idx_ff[IDX_W-1:0];
               mem_req.wr_data = value_ff;
               count_in        = count_ff + CNT_W'(1);
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = step_sum[IDX_W-1:0];
            end
         end
         S_INS_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IDX_W-1:0];
            mem_req.wr_data = rd_data;
            idx_in          = step_sum;
         end
         S_DEL_STEP: begin
            if (at_end) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = step_sum[IDX_W-1:0];
            end
         end
         S_DEL_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff[IDX_W-1:0];
            mem_req.wr_data = rd_data;
            idx_in          = step_sum;
         end
         S_SRCH_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff[IDX_W-1:0];
         end
         S_SRCH_CMP: begin
            // on a hit, hold the index for the result
            if (!hit) begin
               if (at_end) begin
                  status_in = STAT_NOTFOUND;
               end else begin
                  idx_in = step_sum;
               end
            end
         end
         S_DUMP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff[IDX_W-1:0];
         end
         S_DUMP_OUT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_found_in  = idx_ff;
               rsp_entry_in  = rd_data;
               rsp_last_in   = at_end;
               if (!at_end) begin
                  idx_in = step_sum;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if ((cmd_ff == CMD_SEARCH) && (status_ff == STAT_OK)) begin
                  rsp_found_in = idx_ff;
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // advance valid on load, drop it once taken
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // latch the command on acceptance
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= in_cmd;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   // hold the result payload while stalled
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_length_ff <= rsp_length_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_value    = rsp_entry_ff;
   assign rsp_length         = rsp_length_ff;
   assign rsp_last           = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `PLE_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "list length over capacity")
   `PLE_ASSERT_NEXT(a_count_step, 1'b1, (count_ff == $past(count_ff)) || (count_ff == ($past(count_ff) + CNT_W'(1))) || (count_ff == ($past(count_ff) - CNT_W'(1))), "list length jumped")
   `PLE_ASSERT_ALWAYS(a_mid_dump, !(rsp_valid_ff && !rsp_last_ff) || (cmd_ff == CMD_DUMP), "non-final item outside dump")
   `PLE_ASSERT_NEXT(a_dump_hold, (state_ff == S_DUMP_OUT) && !out_free, $stable(rd_data), "dump data lost while stalled")

endmodule
